/* src/dns_a_response_parser_unit_defines.svh */
// Assertion macros shared by the parser modules.
`ifndef DNS_A_RESPONSE_PARSER_UNIT_DEFINES_SVH
`define DNS_A_RESPONSE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define DNSAP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define DNSAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dnsap_pkg.sv */
package dnsap_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = 32;
    localparam int TTL_W    = 32;
    localparam int COUNT_W  = 10;

    // Limits
    localparam int MAX_PACKET = 512;
    localparam int MAX_LABELS = 128;
    localparam int HDR_BYTES  = 12;

    // Verdict codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SERVFAIL  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd5;

    // Header flag positions and record constants
    localparam int              FLAG_QR_BIT   = 15;
    localparam int              FLAG_TC_BIT   = 9;
    localparam logic [3:0]      RCODE_NXDOMAIN = 4'd3;
    localparam logic [15:0]     TYPE_A        = 16'd1;
    localparam logic [15:0]     CLASS_IN      = 16'd1;
    localparam logic [15:0]     A_RDATA_LEN   = 16'd4;

    // One verdict word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   resolved_address;
        logic [TTL_W-1:0]    answer_ttl;
    } t_result;

endpackage

/* src/dnsap_if.sv */
// Byte channel into the parser
interface dnsap_byte_if;
    logic                          valid;
    logic                          ready;
    logic [dnsap_pkg::BYTE_W-1:0]  data_byte;
    logic                          last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Verdict channel out of the parser
interface dnsap_result_if;
    logic                            valid;
    logic                            ready;
    logic [dnsap_pkg::STATUS_W-1:0]  status;
    logic [dnsap_pkg::ADDR_W-1:0]    resolved_address;
    logic [dnsap_pkg::TTL_W-1:0]     answer_ttl;

    modport source (output valid, output status, output resolved_address,
                    output answer_ttl, input ready);
    modport sink   (input valid, input status, input resolved_address,
                    input answer_ttl, output ready);
endinterface

/* src/dnsap_parser.sv */
`include "dns_a_response_parser_unit_defines.svh"

module dnsap_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic [dnsap_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                              i_last_byte,
    input  logic [dnsap_pkg::ID_W-1:0]        i_expected_id,
    output dnsap_pkg::t_result                o_result
);

    // Parse phases
    localparam logic [3:0] PH_HEADER = 4'd0;
    localparam logic [3:0] PH_QNAME  = 4'd1;
    localparam logic [3:0] PH_QLABEL = 4'd2;
    localparam logic [3:0] PH_QPTR   = 4'd3;
    localparam logic [3:0] PH_QFIXED = 4'd4;
    localparam logic [3:0] PH_ANAME  = 4'd5;
    localparam logic [3:0] PH_ALABEL = 4'd6;
    localparam logic [3:0] PH_APTR   = 4'd7;
    localparam logic [3:0] PH_AFIXED = 4'd8;
    localparam logic [3:0] PH_RDATA  = 4'd9;
    localparam logic [3:0] PH_DONE   = 4'd10;

    localparam logic [dnsap_pkg::COUNT_W-1:0] CNT_PKT_MAX =
        dnsap_pkg::COUNT_W'(dnsap_pkg::MAX_PACKET);
    localparam logic [dnsap_pkg::COUNT_W-1:0] CNT_HDR_LAST =
        dnsap_pkg::COUNT_W'(dnsap_pkg::HDR_BYTES - 1);
    localparam logic [7:0] LABELS_MAX = 8'(dnsap_pkg::MAX_LABELS);

    logic [dnsap_pkg::COUNT_W-1:0]  r_byte_count;
    logic [3:0]                     r_phase,       n_phase;
    logic [15:0]                    r_id,          n_id;
    logic [15:0]                    r_flags,       n_flags;
    logic [15:0]                    r_questions,   n_questions;
    logic [15:0]                    r_answers,     n_answers;
    logic [5:0]                     r_label_left,  n_label_left;
    logic [7:0]                     r_labels,      n_labels;
    logic [3:0]                     r_field,       n_field;
    logic [15:0]                    r_rtype,       n_rtype;
    logic [15:0]                    r_rclass,      n_rclass;
    logic [31:0]                    r_ttl,         n_ttl;
    logic [15:0]                    r_rdata_left,  n_rdata_left;
    logic [31:0]                    r_addr,        n_addr;
    logic                           r_latched,     n_latched;
    logic [dnsap_pkg::STATUS_W-1:0] r_status,      n_status;

    logic                           do_next_q;
    logic                           do_next_a;
    logic                           do_latch;
    logic [dnsap_pkg::STATUS_W-1:0] latch_code;
    logic                           is_answer;
    logic [dnsap_pkg::STATUS_W-1:0] verdict;

    // Advance the parse by one byte
    always_comb begin
        n_phase      = r_phase;
        n_id         = r_id;
        n_flags      = r_flags;
        n_questions  = r_questions;
        n_answers    = r_answers;
        n_label_left = r_label_left;
        n_labels     = r_labels;
        n_field      = r_field;
        n_rtype      = r_rtype;
        n_rclass     = r_rclass;
        n_ttl        = r_ttl;
        n_rdata_left = r_rdata_left;
        n_addr       = r_addr;
        n_latched    = r_latched;
        n_status     = r_status;
        do_next_q    = 1'b0;
        do_next_a    = 1'b0;
        do_latch     = 1'b0;
        latch_code   = dnsap_pkg::ST_MALFORMED;
        is_answer    = (r_phase == PH_ANAME);

        unique case (r_phase) inside
            PH_HEADER: begin
                if (r_byte_count <= 10'd1) begin
                    n_id = {r_id[7:0], i_data_byte};
                end else if (r_byte_count <= 10'd3) begin
                    n_flags = {r_flags[7:0], i_data_byte};
                end else if (r_byte_count <= 10'd5) begin
                    n_questions = {r_questions[7:0], i_data_byte};
                end else if (r_byte_count <= 10'd7) begin
                    n_answers = {r_answers[7:0], i_data_byte};
                end
                // Judge the header flags on its final byte
                if (r_byte_count == CNT_HDR_LAST) begin
                    if (!r_flags[dnsap_pkg::FLAG_QR_BIT]) begin
                        do_latch   = 1'b1;
                        latch_code = dnsap_pkg::ST_MALFORMED;
                    end else if (r_flags[dnsap_pkg::FLAG_TC_BIT]) begin
                        do_latch   = 1'b1;
                        latch_code = dnsap_pkg::ST_TRUNCATED;
                    end else if (r_flags[3:0] != 4'd0) begin
                        do_latch   = 1'b1;
                        latch_code = (r_flags[3:0] == dnsap_pkg::RCODE_NXDOMAIN)
                                   ? dnsap_pkg::ST_NOTFOUND : dnsap_pkg::ST_SERVFAIL;
                    end else begin
                        do_next_q = 1'b1;
                    end
                end
            end
            PH_QNAME, PH_ANAME: begin
                // Label length, name end or compression pointer
                if (r_labels >= LABELS_MAX) begin
                    do_latch = 1'b1;
                end else if (i_data_byte == 8'd0) begin
                    n_phase = is_answer ? PH_AFIXED : PH_QFIXED;
                    n_field = 4'd0;
                end else if (i_data_byte[7:6] == 2'b11) begin
                    n_phase = is_answer ? PH_APTR : PH_QPTR;
                end else if (i_data_byte[7:6] != 2'b00) begin
                    do_latch = 1'b1;
                end else begin
                    n_label_left = i_data_byte[5:0];
                    n_labels     = r_labels + 8'd1;
                    n_phase      = is_answer ? PH_ALABEL : PH_QLABEL;
                end
            end
            PH_QLABEL, PH_ALABEL: begin
                n_label_left = r_label_left - 6'd1;
                if (n_label_left == 6'd0) begin
                    n_phase = (r_phase == PH_QLABEL) ? PH_QNAME : PH_ANAME;
                end
            end
            PH_QPTR: begin
                n_phase = PH_QFIXED;
                n_field = 4'd0;
            end
            PH_APTR: begin
                n_phase = PH_AFIXED;
                n_field = 4'd0;
            end
            PH_QFIXED: begin
                // Skip QTYPE and QCLASS
                if (r_field >= 4'd3) begin
                    n_questions = r_questions - 16'd1;
                    do_next_q   = 1'b1;
                end else begin
                    n_field = r_field + 4'd1;
                end
            end
            PH_AFIXED: begin
                // Shift in TYPE, CLASS, TTL and RDLENGTH
                if (r_field <= 4'd1) begin
                    n_rtype = {r_rtype[7:0], i_data_byte};
                end else if (r_field <= 4'd3) begin
                    n_rclass = {r_rclass[7:0], i_data_byte};
                end else if (r_field <= 4'd7) begin
                    n_ttl = {r_ttl[23:0], i_data_byte};
                end else begin
                    n_rdata_left = {r_rdata_left[7:0], i_data_byte};
                end
                if (r_field >= 4'd9) begin
                    if (!(n_rtype == dnsap_pkg::TYPE_A && n_rclass == dnsap_pkg::CLASS_IN
                          && n_rdata_left == dnsap_pkg::A_RDATA_LEN)) begin
                        n_rtype = 16'd0;
                    end
                    n_addr = 32'd0;
                    if (n_rdata_left == 16'd0) begin
                        n_answers = r_answers - 16'd1;
                        do_next_a = 1'b1;
                    end else begin
                        n_phase = PH_RDATA;
                    end
                end else begin
                    n_field = r_field + 4'd1;
                end
            end
            PH_RDATA: begin
                n_addr       = {r_addr[23:0], i_data_byte};
                n_rdata_left = r_rdata_left - 16'd1;
                if (n_rdata_left == 16'd0) begin
                    if (r_rtype == dnsap_pkg::TYPE_A) begin
                        do_latch   = 1'b1;
                        latch_code = dnsap_pkg::ST_OK;
                    end else begin
                        n_answers = r_answers - 16'd1;
                        do_next_a = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        // Move on to the next question, the next answer, or run out
        if (do_next_q) begin
            if (n_questions != 16'd0) begin
                n_phase  = PH_QNAME;
                n_labels = 8'd0;
            end else begin
                do_next_a = 1'b1;
            end
        end
        if (do_next_a) begin
            if (n_answers != 16'd0) begin
                n_phase  = PH_ANAME;
                n_labels = 8'd0;
            end else begin
                do_latch   = 1'b1;
                latch_code = dnsap_pkg::ST_NOTFOUND;
            end
        end
        if (do_latch) begin
            n_latched = 1'b1;
            n_status  = latch_code;
            n_phase   = PH_DONE;
        end
    end

    // Resolve the verdict for a final byte
    always_comb begin
        if (r_byte_count >= CNT_PKT_MAX) begin
            verdict = dnsap_pkg::ST_IGNORED;
        end else if (r_byte_count == '0) begin
            verdict = dnsap_pkg::ST_MALFORMED;
        end else if (n_id != i_expected_id) begin
            verdict = dnsap_pkg::ST_IGNORED;
        end else if (n_latched) begin
            verdict = n_status;
        end else begin
            verdict = dnsap_pkg::ST_MALFORMED;
        end
        o_result.status           = verdict;
        o_result.resolved_address = (verdict == dnsap_pkg::ST_OK) ? n_addr : 32'd0;
        o_result.answer_ttl       = (verdict == dnsap_pkg::ST_OK) ? n_ttl : 32'd0;
    end

    // Hold parse state; clear it on reset and after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_byte_count <= '0;
            r_phase      <= PH_HEADER;
            r_id         <= '0;
            r_flags      <= '0;
            r_questions  <= '0;
            r_answers    <= '0;
            r_label_left <= '0;
            r_labels     <= '0;
            r_field      <= '0;
            r_rtype      <= '0;
            r_rclass     <= '0;
            r_ttl        <= '0;
            r_rdata_left <= '0;
            r_addr       <= '0;
            r_latched    <= 1'b0;
            r_status     <= '0;
        end else if (i_step) begin
            if (r_byte_count != '1) begin
                r_byte_count <= r_byte_count + 1'b1;
            end
            r_phase      <= n_phase;
            r_id         <= n_id;
            r_flags      <= n_flags;
            r_questions  <= n_questions;
            r_answers    <= n_answers;
            r_label_left <= n_label_left;
            r_labels     <= n_labels;
            r_field      <= n_field;
            r_rtype      <= n_rtype;
            r_rclass     <= n_rclass;
            r_ttl        <= n_ttl;
            r_rdata_left <= n_rdata_left;
            r_addr       <= n_addr;
            r_latched    <= n_latched;
            r_status     <= n_status;
        end
    end

    `DNSAP_ASSERT_NOW(a_done_latched, i_clk, i_rst_n, r_phase == PH_DONE, r_latched, "done phase without a latched verdict")
    `DNSAP_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, i_step && i_last_byte, r_phase == PH_HEADER && r_byte_count == '0 && !r_latched, "state not cleared after final byte")

endmodule

/* src/dns_a_response_parser_unit.sv */
// DNS A-record response parser. Bytes of one response payload enter on i_byte,
// one word per clock, with last_byte set on the final one; exactly one verdict
// word leaves on o_result for each packet once its final byte has passed the
// input register and then the result register. Throughput is one byte
// per cycle; the input side stalls only when a final byte reaches the input
// register while the previous verdict still waits in the result register.
// expected_id is written through i_cfg_we / i_cfg_data and must only change
// while no packet is in flight. Packets over 512 bytes or with a foreign ID
// give status ignored; resolved_address and answer_ttl are zero unless ok.
`include "dns_a_response_parser_unit_defines.svh"

module dns_a_response_parser_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dnsap_byte_if.sink                    i_byte,
    dnsap_result_if.source                o_result,
    input  logic                          i_cfg_we,
    input  logic [dnsap_pkg::ID_W-1:0]    i_cfg_data
);

    logic                         r_in_valid;
    logic [dnsap_pkg::BYTE_W-1:0] r_in_byte;
    logic                         r_in_last;
    logic                         r_out_valid;
    dnsap_pkg::t_result           r_out;
    logic [dnsap_pkg::ID_W-1:0]   r_expected_id;

    logic                         out_free;
    logic                         advance;
    dnsap_pkg::t_result           verdict;

    assign out_free     = !r_out_valid || o_result.ready;
    assign advance      = r_in_valid && (!r_in_last || out_free);
    assign i_byte.ready = !r_in_valid || advance;

    // Hold the expected transaction ID
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= '0;
        end else if (i_cfg_we) begin
            r_expected_id <= i_cfg_data;
        end
    end

    // Input register: load a word, drop it once parsed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
    end

    dnsap_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_data_byte   (r_in_byte),
        .i_last_byte   (r_in_last),
        .i_expected_id (r_expected_id),
        .o_result      (verdict)
    );

    // Result register: load on the final byte, release when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= verdict;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.status           = r_out.status;
    assign o_result.resolved_address = r_out.resolved_address;
    assign o_result.answer_ttl       = r_out.answer_ttl;

    `DNSAP_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, r_in_valid && r_in_last && r_out_valid && !o_result.ready, !advance && !i_byte.ready, "final byte parsed while verdict pending")
    `DNSAP_ASSERT_NEXT(a_verdict_loaded, i_clk, i_rst_n, advance && r_in_last, r_out_valid, "verdict not presented after final byte")
    `DNSAP_ASSERT_NOW(a_zero_unless_ok, i_clk, i_rst_n, r_out_valid && r_out.status != dnsap_pkg::ST_OK, r_out.resolved_address == '0 && r_out.answer_ttl == '0, "address or ttl set on a failed verdict")

endmodule
